@@ design/pmk_pkg.sv @@
// Types, constants and helpers shared by the paddle keyer modules.
package pmk_pkg;

    localparam int DIT_W   = 11;
    localparam int DAH_W   = 12;
    localparam int TS_W    = 32;
    localparam int CODE_W  = 3;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIT_W-1:0] DIT_RESET = 11'd80;
    localparam logic [DAH_W-1:0] DAH_RESET = 12'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_DIT_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAH_LENGTH = 1'b1;

    localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_DIT     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DAH     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_ENDCHAR = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ENDWORD = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_DIT     = 5'b00010,
        PH_DAH     = 5'b00100,
        PH_ENDCHAR = 5'b01000,
        PH_ENDWORD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [TS_W-1:0] now_ms;
        logic            dit_paddle;
        logic            dah_paddle;
    } pmk_in_t;

    typedef struct packed {
        logic              key_on;
        logic [CODE_W-1:0] keyer_phase;
    } pmk_out_t;

    typedef struct packed {
        logic [DIT_W-1:0] dit_length;
        logic [DAH_W-1:0] dah_length;
    } pmk_cfg_t;

    function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
        logic [CODE_W-1:0] code;
        unique case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_DIT:     code = CODE_DIT;
            PH_DAH:     code = CODE_DAH;
            PH_ENDCHAR: code = CODE_ENDCHAR;
            PH_ENDWORD: code = CODE_ENDWORD;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ design/pmk_step.sv @@
// Keyer state registers and the next-state logic for one loop pass.
module pmk_step
    import pmk_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  pmk_in_t  item,
    input  pmk_cfg_t cfg,
    output pmk_out_t result
);

    phase_t               phase_reg, phase_next;
    phase_t               queued_phase_reg, queued_phase_next;
    logic                 queued_valid_reg, queued_valid_next;
    logic                 dit_active_reg, dit_active_next;
    logic                 dit_done_reg, dit_done_next;
    logic                 dah_active_reg, dah_active_next;
    logic                 dah_done_reg, dah_done_next;
    logic                 gap_active_reg, gap_active_next;
    logic [TIME_BITS-1:0] dit_start_reg, dit_start_next;
    logic [TIME_BITS-1:0] dah_start_reg, dah_start_next;
    logic [TIME_BITS-1:0] gap_start_reg, gap_start_next;
    logic                 key_level_reg, key_level_next;

    logic [TIME_BITS-1:0] t;
    logic                 is_dah;
    logic                 el_act, el_done, el_act_n, el_done_n;
    logic [TIME_BITS-1:0] el_start, el_start_n;
    logic [TIME_BITS-1:0] el_len;
    logic                 other;
    phase_t               opposite;
    logic [TIME_BITS-1:0] el_elapsed;
    logic [TIME_BITS-1:0] gap_elapsed;
    logic [TIME_BITS-1:0] wait_base;
    logic [TIME_BITS-1:0] wait_elapsed;
    logic [TIME_BITS-1:0] wait_limit;
    logic [TIME_BITS-1:0] dit_wide;

    assign t        = TIME_BITS'(item.now_ms);
    assign is_dah   = (phase_reg == PH_DAH);
    assign el_act   = is_dah ? dah_active_reg : dit_active_reg;
    assign el_done  = is_dah ? dah_done_reg : dit_done_reg;
    assign el_start = is_dah ? dah_start_reg : dit_start_reg;
    assign el_len   = is_dah ? TIME_BITS'(cfg.dah_length) : TIME_BITS'(cfg.dit_length);
    assign other    = is_dah ? item.dit_paddle : item.dah_paddle;
    assign opposite = is_dah ? PH_DIT : PH_DAH;
    assign dit_wide = TIME_BITS'(cfg.dit_length);

    // all differences wrap at the timestamp width
    assign el_elapsed   = t - el_start;
    assign gap_elapsed  = t - gap_start_reg;
    assign wait_base    = gap_active_reg ? gap_start_reg : t;
    assign wait_elapsed = t - wait_base;
    assign wait_limit   = (phase_reg == PH_ENDWORD) ? TIME_BITS'({cfg.dit_length, 2'b00})
                                                    : TIME_BITS'({cfg.dit_length, 1'b0});

    always_comb
    begin
        phase_next        = phase_reg;
        queued_phase_next = queued_phase_reg;
        queued_valid_next = queued_valid_reg;
        gap_active_next   = gap_active_reg;
        gap_start_next    = gap_start_reg;
        key_level_next    = key_level_reg;
        el_act_n          = el_act;
        el_done_n         = el_done;
        el_start_n        = el_start;

        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (item.dit_paddle)
                    phase_next = PH_DIT;
                else if (item.dah_paddle)
                    phase_next = PH_DAH;
            end
            PH_DIT, PH_DAH:
            begin
                if (!el_act && !el_done)
                begin
                    el_act_n       = 1'b1;
                    el_start_n     = t;
                    key_level_next = 1'b1;
                end
                else if (el_act && !el_done)
                begin
                    if (el_elapsed >= el_len)
                    begin
                        el_start_n      = '0;
                        el_act_n        = 1'b0;
                        el_done_n       = 1'b1;
                        key_level_next  = 1'b0;
                        gap_active_next = 1'b1;
                        gap_start_next  = t;
                    end
                    else if (other)
                    begin
                        queued_valid_next = 1'b1;
                        queued_phase_next = opposite;
                    end
                end
                else if (!el_act && el_done)
                begin
                    if (gap_elapsed > dit_wide)
                    begin
                        phase_next        = queued_phase_reg;
                        queued_valid_next = 1'b0;
                        gap_active_next   = 1'b0;
                        gap_start_next    = '0;
                        el_done_n         = 1'b0;
                    end
                    else if (!queued_valid_reg)
                    begin
                        // both paddles held: alternate
                        if (item.dit_paddle && item.dah_paddle)
                        begin
                            queued_phase_next = opposite;
                            queued_valid_next = 1'b1;
                        end
                        else if (item.dah_paddle)
                        begin
                            queued_phase_next = PH_DAH;
                            queued_valid_next = 1'b1;
                        end
                        else if (item.dit_paddle)
                        begin
                            queued_phase_next = PH_DIT;
                            queued_valid_next = 1'b1;
                        end
                        else
                            queued_phase_next = PH_ENDCHAR;
                    end
                end
            end
            PH_ENDCHAR, PH_ENDWORD:
            begin
                gap_active_next = 1'b1;
                gap_start_next  = wait_base;
                if (wait_elapsed > wait_limit)
                begin
                    phase_next        = queued_phase_reg;
                    queued_valid_next = 1'b0;
                    gap_active_next   = 1'b0;
                    gap_start_next    = '0;
                end
                else if (!queued_valid_reg)
                begin
                    if (item.dah_paddle)
                    begin
                        queued_phase_next = PH_DAH;
                        queued_valid_next = 1'b1;
                    end
                    else if (item.dit_paddle)
                    begin
                        queued_phase_next = PH_DIT;
                        queued_valid_next = 1'b1;
                    end
                    else
                        queued_phase_next = (phase_reg == PH_ENDCHAR) ? PH_ENDWORD : PH_IDLE;
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // route the shared element update back to the dit or dah flags
    always_comb
    begin
        dit_active_next = dit_active_reg;
        dit_done_next   = dit_done_reg;
        dit_start_next  = dit_start_reg;
        dah_active_next = dah_active_reg;
        dah_done_next   = dah_done_reg;
        dah_start_next  = dah_start_reg;
        if (phase_reg == PH_DIT)
        begin
            dit_active_next = el_act_n;
            dit_done_next   = el_done_n;
            dit_start_next  = el_start_n;
        end
        else if (phase_reg == PH_DAH)
        begin
            dah_active_next = el_act_n;
            dah_done_next   = el_done_n;
            dah_start_next  = el_start_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            queued_phase_reg <= PH_IDLE;
            queued_valid_reg <= 1'b0;
            dit_active_reg   <= 1'b0;
            dit_done_reg     <= 1'b0;
            dah_active_reg   <= 1'b0;
            dah_done_reg     <= 1'b0;
            gap_active_reg   <= 1'b0;
            dit_start_reg    <= '0;
            dah_start_reg    <= '0;
            gap_start_reg    <= '0;
            key_level_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            queued_phase_reg <= queued_phase_next;
            queued_valid_reg <= queued_valid_next;
            dit_active_reg   <= dit_active_next;
            dit_done_reg     <= dit_done_next;
            dah_active_reg   <= dah_active_next;
            dah_done_reg     <= dah_done_next;
            gap_active_reg   <= gap_active_next;
            dit_start_reg    <= dit_start_next;
            dah_start_reg    <= dah_start_next;
            gap_start_reg    <= gap_start_next;
            key_level_reg    <= key_level_next;
        end
    end

    assign result.key_on      = key_level_next;
    assign result.keyer_phase = phase_code(phase_next);

endmodule

@@ design/paddle_morse_keyer.sv @@
// Top level of the paddle keyer: configuration registers, handshake and result register.
//
// Each input transfer is one pass of the keyer loop: a millisecond timestamp
// and the dit and dah paddle levels. Every accepted item yields exactly one
// result (key_on and keyer_phase) that shows in the output register on the
// cycle after the transfer.
// Throughput is one item per cycle while the output is not stalled: the state update is a single pass through
// the next-state logic, set by the wrapping timestamp subtract and compare.
// The input side is stalled only while a result sits in the output register
// and the receiver stalls it; a result being taken frees the register for the
// next item in the same cycle.
// Configuration: cfg_write with cfg_index 0 loads dit_length (11 bits), index
// 1 loads dah_length (12 bits). Write only while no item is in flight.
// Reset: asynchronous, active low. Keyer goes idle with key up, lengths
// return to 80 ms and 240 ms, and the output register empties.
module paddle_morse_keyer
    import pmk_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pmk_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pmk_out_t             out_data
);

    pmk_cfg_t cfg_reg;
    logic     out_valid_reg;
    pmk_out_t out_data_reg;
    pmk_out_t step_result;
    logic     accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dit_length <= DIT_RESET;
            cfg_reg.dah_length <= DAH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIT_LENGTH: cfg_reg.dit_length <= cfg_data[DIT_W-1:0];
                CFG_DAH_LENGTH: cfg_reg.dah_length <= cfg_data[DAH_W-1:0];
            endcase
        end
    end

    pmk_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .item    (in_data),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // hold the result until its transfer completes
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ bench/keyer_phase_monitor.sv @@
// Keyer channel monitor: mirrors the keyer state, predicts every pass and compares results.
module keyer_phase_monitor
    import pmk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  pmk_in_t              in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  pmk_out_t             out_data,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DIT_W-1:0]  dit_len;
    logic [DAH_W-1:0]  dah_len;
    logic [CODE_W-1:0] cur_phase;
    logic [CODE_W-1:0] next_phase;
    logic              next_valid;
    logic              elem_active [2];
    logic              elem_done   [2];
    logic [TS_W-1:0]   elem_start  [2];
    logic              gap_on;
    logic [TS_W-1:0]   gap_start;
    logic              key_level;
    pmk_out_t          expected_keying [$];

    task automatic reset_keyer();
        dit_len    = DIT_RESET;
        dah_len    = DAH_RESET;
        cur_phase  = CODE_IDLE;
        next_phase = CODE_IDLE;
        next_valid = 1'b0;
        gap_on     = 1'b0;
        gap_start  = '0;
        key_level  = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            elem_active[i] = 1'b0;
            elem_done[i]   = 1'b0;
            elem_start[i]  = '0;
        end
    endtask

    // Move to whatever is queued, even a stale entry from an earlier gap.
    task automatic take_queued();
        cur_phase  = next_phase;
        next_valid = 1'b0;
        gap_on     = 1'b0;
        gap_start  = '0;
    endtask

    task automatic run_element(input logic is_dah, input logic [TS_W-1:0] t,
                               input logic dit, input logic dah);
        logic [TS_W-1:0]   len;
        logic [TS_W-1:0]   spent;
        logic              other;
        logic [CODE_W-1:0] opposite;
        len      = is_dah ? TS_W'(dah_len) : TS_W'(dit_len);
        other    = is_dah ? dit : dah;
        opposite = is_dah ? CODE_DIT : CODE_DAH;
        if (!elem_active[is_dah] && !elem_done[is_dah])
        begin
            elem_active[is_dah] = 1'b1;
            elem_start[is_dah]  = t;
            key_level           = 1'b1;
            return;
        end
        if (elem_active[is_dah] && !elem_done[is_dah])
        begin
            spent = t - elem_start[is_dah];
            if (spent >= len)
            begin
                elem_start[is_dah]  = '0;
                elem_active[is_dah] = 1'b0;
                elem_done[is_dah]   = 1'b1;
                key_level           = 1'b0;
                gap_on              = 1'b1;
                gap_start           = t;
                return;
            end
            // latch the opposite paddle as the next element
            if (other)
            begin
                next_valid = 1'b1;
                next_phase = opposite;
            end
        end
        if (!elem_active[is_dah] && elem_done[is_dah])
        begin
            spent = t - gap_start;
            if (spent > TS_W'(dit_len))
            begin
                take_queued();
                elem_done[is_dah] = 1'b0;
                return;
            end
            if (!next_valid)
            begin
                if (dit && dah)
                begin
                    next_phase = opposite;
                    next_valid = 1'b1;
                end
                else if (dah)
                begin
                    next_phase = CODE_DAH;
                    next_valid = 1'b1;
                end
                else if (dit)
                begin
                    next_phase = CODE_DIT;
                    next_valid = 1'b1;
                end
                else
                    next_phase = CODE_ENDCHAR;
            end
        end
    endtask

    task automatic run_wait(input logic [TS_W-1:0] t, input int units,
                            input logic [CODE_W-1:0] fallback,
                            input logic dit, input logic dah);
        logic [TS_W-1:0] limit;
        logic [TS_W-1:0] spent;
        if (!gap_on)
        begin
            gap_on    = 1'b1;
            gap_start = t;
        end
        limit = TS_W'(dit_len) * TS_W'(units);
        spent = t - gap_start;
        if (spent > limit)
        begin
            take_queued();
            return;
        end
        if (!next_valid)
        begin
            if (dah)
            begin
                next_phase = CODE_DAH;
                next_valid = 1'b1;
            end
            else if (dit)
            begin
                next_phase = CODE_DIT;
                next_valid = 1'b1;
            end
            else
                next_phase = fallback;
        end
    endtask

    task automatic advance_keyer(input pmk_in_t pass, output pmk_out_t result);
        case (cur_phase)
            CODE_IDLE:
            begin
                if (pass.dit_paddle)
                    cur_phase = CODE_DIT;
                else if (pass.dah_paddle)
                    cur_phase = CODE_DAH;
            end
            CODE_DIT:     run_element(1'b0, pass.now_ms, pass.dit_paddle, pass.dah_paddle);
            CODE_DAH:     run_element(1'b1, pass.now_ms, pass.dit_paddle, pass.dah_paddle);
            CODE_ENDCHAR: run_wait(pass.now_ms, 2, CODE_ENDWORD,
                                   pass.dit_paddle, pass.dah_paddle);
            CODE_ENDWORD: run_wait(pass.now_ms, 4, CODE_IDLE,
                                   pass.dit_paddle, pass.dah_paddle);
            default:      cur_phase = CODE_IDLE;
        endcase
        result.key_on      = key_level;
        result.keyer_phase = cur_phase;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pmk_out_t want;
        int       bad;
        bad = 0;
        if (!rst_n)
        begin
            reset_keyer();
            expected_keying.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_DIT_LENGTH)
                    dit_len = cfg_data[DIT_W-1:0];
                else if (cfg_index == CFG_DAH_LENGTH)
                    dah_len = cfg_data[DAH_W-1:0];
            end
            // compare the result transfer before queuing this edge's prediction
            if (out_valid && !out_stall)
            begin
                if (expected_keying.size() == 0)
                begin
                    $display("%0t: unexpected result key_on %0b phase %0d", $time,
                             out_data.key_on, out_data.keyer_phase);
                    bad++;
                end
                else
                begin
                    want = expected_keying.pop_front();
                    if (out_data.key_on !== want.key_on)
                    begin
                        $display("%0t: key_on expected %0b, got %0b", $time,
                                 want.key_on, out_data.key_on);
                        bad++;
                    end
                    if (out_data.keyer_phase !== want.keyer_phase)
                    begin
                        $display("%0t: keyer_phase expected %0d, got %0d", $time,
                                 want.keyer_phase, out_data.keyer_phase);
                        bad++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_keyer(in_data, want);
                expected_keying.push_back(want);
            end
            errors  <= errors + bad;
            pending <= expected_keying.size();
        end
    end

endmodule

@@ bench/paddle_morse_keyer_test.sv @@
// Top of the paddle keyer testbench: clock, reset, stimulus phases and the verdict.
module paddle_morse_keyer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pmk_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DIT_LENGTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    pmk_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pmk_out_t             out_data;
    int                   keying_errors;
    int                   results_due;

    int                   idle_pct    = 0;
    int                   stall_pct   = 0;
    int                   dit_setting = 80;
    logic [TS_W-1:0]      timeline_ms = '0;
    logic                 dit_held    = 1'b0;
    logic                 dah_held    = 1'b0;

    always #2 clk = ~clk;

    paddle_morse_keyer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    keyer_phase_monitor monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (keying_errors),
        .pending   (results_due)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic send_pass(input logic [TS_W-1:0] t, input logic dit, input logic dah);
        pmk_in_t item;
        item.now_ms     = t;
        item.dit_paddle = dit;
        item.dah_paddle = dah;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        // hold the payload until the transfer happens
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic load_lengths(input int dit_ms, input int dah_ms);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DIT_LENGTH;
        cfg_data  <= CFG_W'(dit_ms);
        @(posedge clk);
        cfg_index <= CFG_DAH_LENGTH;
        cfg_data  <= CFG_W'(dah_ms);
        @(posedge clk);
        cfg_write <= 1'b0;
        dit_setting = dit_ms;
    endtask

    task automatic set_phase(input int idle, input int stall, input int dit_ms,
                             input int dah_ms);
        drain_results();
        repeat (3) @(posedge clk);
        load_lengths(dit_ms, dah_ms);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // Realistic keying: time creeps forward by up to half a dit plus 2 ms and the paddles
    // are held for stretches; now and then the clock jumps anywhere.
    task automatic run_random(input int count, input int pause_at);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                drain_results();
            if ($urandom_range(99) < 3)
                timeline_ms = $urandom();
            else
                timeline_ms += $urandom_range(0, dit_setting / 2 + 2);
            if ($urandom_range(99) < 15)
            begin
                pick     = $urandom_range(9);
                dit_held = (pick == 4 || pick == 5 || pick >= 8);
                dah_held = (pick >= 6);
            end
            send_pass(timeline_ms, dit_held, dah_held);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full dit-dah-dit character, then the character and word gaps
        send_pass(32'd0, 1'b0, 1'b0);
        send_pass(32'd0, 1'b1, 1'b0);
        send_pass(32'd10, 1'b1, 1'b0);
        send_pass(32'd50, 1'b0, 1'b1);
        send_pass(32'd90, 1'b0, 1'b0);
        send_pass(32'd100, 1'b1, 1'b1);
        send_pass(32'd171, 1'b0, 1'b0);
        send_pass(32'd172, 1'b0, 1'b0);
        send_pass(32'd300, 1'b1, 1'b0);
        send_pass(32'd412, 1'b0, 1'b0);
        send_pass(32'd420, 1'b0, 1'b0);
        send_pass(32'd493, 1'b0, 1'b0);
        send_pass(32'd494, 1'b0, 1'b0);
        send_pass(32'd574, 1'b0, 1'b0);
        send_pass(32'd580, 1'b0, 1'b0);
        send_pass(32'd655, 1'b0, 1'b0);
        send_pass(32'd656, 1'b0, 1'b0);
        send_pass(32'd817, 1'b0, 1'b0);
        send_pass(32'd818, 1'b0, 1'b0);
        send_pass(32'd1139, 1'b0, 1'b0);
        // dah across the timestamp wrap, then a backward jump hits a stale queue
        send_pass(32'hFFFF_FFF0, 1'b0, 1'b1);
        send_pass(32'hFFFF_FFF8, 1'b0, 1'b1);
        send_pass(32'h0000_00F0, 1'b0, 1'b1);
        send_pass(32'h0000_0010, 1'b0, 1'b0);
        send_pass(32'h0000_0020, 1'b1, 1'b1);
        timeline_ms = 32'h0000_0020;

        run_random(110, -1);
        set_phase(82, 0, 1, 3);
        run_random(110, 55);
        set_phase(0, 82, 0, 5);
        run_random(110, -1);
        set_phase(23, 23, 2047, 4095);
        timeline_ms = 32'hFFFF_F000;
        run_random(110, -1);
        set_phase(0, 0, 1200, 3600);
        run_random(110, -1);
        set_phase(82, 0, 7, 21);
        run_random(110, -1);

        drain_results();
        repeat (10) @(posedge clk);
        if (keying_errors == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
